// ===== hw/rtl/ohlc_pkg.sv =====
`default_nettype none

package ohlc_pkg;

  localparam int unsigned MinuteW = 24;
  localparam int unsigned IndexW  = 32;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  // one accepted word, as seen by the bar registers
  typedef struct packed {
    logic tick;
    logic flush;
  } bar_ctl_t;

  typedef struct packed {
    logic emit;
  } bar_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ohlc_bar_aggregator_top.sv =====
`default_nettype none

// One-minute OHLC bar builder. Each input word is a price tick (tuser 0) or a
// flush command (tuser 1). A tick that stays in the open bar's minute is folded
// into the bar registers and the block stays ready. A tick with a new minute, or
// a flush of an open bar, closes the bar: its mean is computed as
// floor(sum * 2^MEAN_FRAC_BITS / count) by a bit-serial divider, so such a word
// holds the input off while the divider runs and until the finished bar can move
// into the output register. The output register holds one bar while upstream
// continues. A flush with no open bar produces nothing. first_tick_index counts
// ticks since reset and wraps at 2^32.
module ohlc_bar_aggregator_top #(
  parameter int unsigned PRICE_BITS        = 20,
  parameter int unsigned MAX_TICKS_PER_BAR = 65536,
  parameter int unsigned MEAN_FRAC_BITS    = 8,
  localparam int unsigned CountW   = $clog2(MAX_TICKS_PER_BAR + 1),
  localparam int unsigned MeanW    = PRICE_BITS + MEAN_FRAC_BITS,
  localparam int unsigned InW      = ohlc_pkg::MinuteW + 2 * PRICE_BITS,
  localparam int unsigned InDataW  = ((InW + 7) / 8) * 8,
  localparam int unsigned OutW     = ohlc_pkg::MinuteW + 4 * PRICE_BITS + MeanW + CountW
                                     + ohlc_pkg::IndexW,
  localparam int unsigned OutDataW = ((OutW + 7) / 8) * 8
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  // tick_minute, bid_price, ask_price
  input  wire  [InDataW-1:0]  s_axis_tdata,
  // cmd
  input  wire                 s_axis_tuser,
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  // bar_minute, open_price, close_price, low_price, high_price, mean_price,
  // tick_count, first_tick_index
  output logic [OutDataW-1:0] m_axis_tdata,
  // count_saturated
  output logic                m_axis_tuser
);

  localparam int unsigned SumW = PRICE_BITS + $clog2(MAX_TICKS_PER_BAR);
  localparam int unsigned DvdW = SumW + MEAN_FRAC_BITS;
  localparam int unsigned MinW = ohlc_pkg::MinuteW;
  localparam int unsigned IdxW = ohlc_pkg::IndexW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_HOLD
  } state_e;

  state_e                  state_q;
  logic                    accept;
  ohlc_pkg::bar_ctl_t      bar_ctl;
  ohlc_pkg::bar_sts_t      bar_sts;
  logic [MinW-1:0]         cur_minute;
  logic [PRICE_BITS-1:0]   cur_open, cur_close, cur_low, cur_high;
  logic [SumW-1:0]         cur_sum;
  logic [CountW-1:0]       cur_count;
  logic [IdxW-1:0]         cur_first;
  logic                    cur_sat;
  logic                    div_start;
  logic                    div_done;
  logic [MeanW-1:0]        div_quo;

  // bar that is waiting for its mean
  logic [MinW-1:0]         pend_minute_q;
  logic [PRICE_BITS-1:0]   pend_open_q, pend_close_q, pend_low_q, pend_high_q;
  logic [CountW-1:0]       pend_count_q;
  logic [IdxW-1:0]         pend_first_q;
  logic                    pend_sat_q;

  logic                    out_valid_q;
  logic [MinW-1:0]         out_minute_q;
  logic [PRICE_BITS-1:0]   out_open_q, out_close_q, out_low_q, out_high_q;
  logic [MeanW-1:0]        out_mean_q;
  logic [CountW-1:0]       out_count_q;
  logic [IdxW-1:0]         out_first_q;
  logic                    out_sat_q;
  logic                    out_load;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign bar_ctl.tick  = accept && (s_axis_tuser == ohlc_pkg::CMD_TICK);
  assign bar_ctl.flush = accept && (s_axis_tuser == ohlc_pkg::CMD_FLUSH);
  assign div_start     = accept && bar_sts.emit;
  assign out_load      = (state_q == S_HOLD) && (!out_valid_q || m_axis_tready);

  ohlc_bar_state #(
    .PRICE_BITS        (PRICE_BITS),
    .MAX_TICKS_PER_BAR (MAX_TICKS_PER_BAR),
    .CountW            (CountW),
    .SumW              (SumW)
  ) u_bar_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (bar_ctl),
    .minute_i      (s_axis_tdata[MinW-1:0]),
    .bid_i         (s_axis_tdata[MinW+PRICE_BITS-1:MinW]),
    .ask_i         (s_axis_tdata[MinW+2*PRICE_BITS-1:MinW+PRICE_BITS]),
    .sts_o         (bar_sts),
    .minute_o      (cur_minute),
    .open_o        (cur_open),
    .close_o       (cur_close),
    .low_o         (cur_low),
    .high_o        (cur_high),
    .sum_o         (cur_sum),
    .count_o       (cur_count),
    .first_index_o (cur_first),
    .saturated_o   (cur_sat)
  );

  ohlc_div #(
    .DvdW (DvdW),
    .DsrW (CountW),
    .QuoW (MeanW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({cur_sum, {MEAN_FRAC_BITS{1'b0}}}),
    .divisor_i  (cur_count),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      pend_minute_q <= '0;
      pend_open_q   <= '0;
      pend_close_q  <= '0;
      pend_low_q    <= '0;
      pend_high_q   <= '0;
      pend_count_q  <= '0;
      pend_first_q  <= '0;
      pend_sat_q    <= 1'b0;
      out_minute_q  <= '0;
      out_open_q    <= '0;
      out_close_q   <= '0;
      out_low_q     <= '0;
      out_high_q    <= '0;
      out_mean_q    <= '0;
      out_count_q   <= '0;
      out_first_q   <= '0;
      out_sat_q     <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (div_start) begin
            // snapshot the closing bar before the new tick overwrites it
            pend_minute_q <= cur_minute;
            pend_open_q   <= cur_open;
            pend_close_q  <= cur_close;
            pend_low_q    <= cur_low;
            pend_high_q   <= cur_high;
            pend_count_q  <= cur_count;
            pend_first_q  <= cur_first;
            pend_sat_q    <= cur_sat;
            state_q       <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) state_q <= S_HOLD;
        end
        S_HOLD: begin
          if (out_load) begin
            out_minute_q <= pend_minute_q;
            out_open_q   <= pend_open_q;
            out_close_q  <= pend_close_q;
            out_low_q    <= pend_low_q;
            out_high_q   <= pend_high_q;
            out_mean_q   <= div_quo;
            out_count_q  <= pend_count_q;
            out_first_q  <= pend_first_q;
            out_sat_q    <= pend_sat_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_sat_q;

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[OutW-1:0] = {out_first_q, out_count_q, out_mean_q, out_high_q, out_low_q,
                              out_close_q, out_open_q, out_minute_q};
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ohlc_bar_state.sv =====
`default_nettype none

module ohlc_bar_state #(
  parameter int unsigned PRICE_BITS        = 20,
  parameter int unsigned MAX_TICKS_PER_BAR = 65536,
  parameter int unsigned CountW            = $clog2(MAX_TICKS_PER_BAR + 1),
  parameter int unsigned SumW              = PRICE_BITS + $clog2(MAX_TICKS_PER_BAR)
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  ohlc_pkg::bar_ctl_t                    ctl_i,
  input  wire        [ohlc_pkg::MinuteW-1:0]    minute_i,
  input  wire        [PRICE_BITS-1:0]           bid_i,
  input  wire        [PRICE_BITS-1:0]           ask_i,
  output ohlc_pkg::bar_sts_t                    sts_o,
  output logic       [ohlc_pkg::MinuteW-1:0]    minute_o,
  output logic       [PRICE_BITS-1:0]           open_o,
  output logic       [PRICE_BITS-1:0]           close_o,
  output logic       [PRICE_BITS-1:0]           low_o,
  output logic       [PRICE_BITS-1:0]           high_o,
  output logic       [SumW-1:0]                 sum_o,
  output logic       [CountW-1:0]               count_o,
  output logic       [ohlc_pkg::IndexW-1:0]     first_index_o,
  output logic                                  saturated_o
);

  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_TICKS_PER_BAR);
  localparam logic [CountW-1:0] OneCount = CountW'(1);

  logic                          bar_open_q, bar_open_d;
  logic [ohlc_pkg::MinuteW-1:0]  minute_q, minute_d;
  logic [PRICE_BITS-1:0]         open_q, open_d;
  logic [PRICE_BITS-1:0]         close_q, close_d;
  logic [PRICE_BITS-1:0]         low_q, low_d;
  logic [PRICE_BITS-1:0]         high_q, high_d;
  logic [SumW-1:0]               sum_q, sum_d;
  logic [CountW-1:0]             count_q, count_d;
  logic [ohlc_pkg::IndexW-1:0]   first_q, first_d;
  logic [ohlc_pkg::IndexW-1:0]   tick_cnt_q, tick_cnt_d;
  logic                          sat_q, sat_d;
  logic [PRICE_BITS:0]           pair_sum;
  logic [PRICE_BITS-1:0]         mid;
  logic                          new_bar;
  logic [CountW-1:0]             count_inc;

  assign pair_sum = {1'b0, bid_i} + {1'b0, ask_i};
  assign mid      = pair_sum[PRICE_BITS:1];
  assign new_bar  = !bar_open_q || (minute_i != minute_q);
  assign count_inc = (count_q < MaxCount) ? count_q + OneCount : count_q;

  assign sts_o.emit = bar_open_q && (ctl_i.flush || (ctl_i.tick && (minute_i != minute_q)));

  always_comb begin
    bar_open_d = bar_open_q;
    minute_d   = minute_q;
    open_d     = open_q;
    close_d    = close_q;
    low_d      = low_q;
    high_d     = high_q;
    sum_d      = sum_q;
    count_d    = count_q;
    first_d    = first_q;
    tick_cnt_d = tick_cnt_q;
    sat_d      = sat_q;
    if (ctl_i.flush) begin
      bar_open_d = 1'b0;
    end else if (ctl_i.tick) begin
      tick_cnt_d = tick_cnt_q + 1'b1;
      close_d    = mid;
      if (new_bar) begin
        bar_open_d = 1'b1;
        minute_d   = minute_i;
        open_d     = mid;
        low_d      = mid;
        high_d     = mid;
        sum_d      = SumW'(mid);
        count_d    = OneCount;
        first_d    = tick_cnt_q;
        sat_d      = (OneCount >= MaxCount);
      end else begin
        if (mid < low_q) low_d = mid;
        if (mid > high_q) high_d = mid;
        // ticks past the bound still move close/low/high but not the mean
        if (count_q < MaxCount) sum_d = sum_q + SumW'(mid);
        count_d = count_inc;
        if (count_inc >= MaxCount) sat_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_open_q <= 1'b0;
      minute_q   <= '0;
      open_q     <= '0;
      close_q    <= '0;
      low_q      <= '0;
      high_q     <= '0;
      sum_q      <= '0;
      count_q    <= '0;
      first_q    <= '0;
      tick_cnt_q <= '0;
      sat_q      <= 1'b0;
    end else begin
      bar_open_q <= bar_open_d;
      minute_q   <= minute_d;
      open_q     <= open_d;
      close_q    <= close_d;
      low_q      <= low_d;
      high_q     <= high_d;
      sum_q      <= sum_d;
      count_q    <= count_d;
      first_q    <= first_d;
      tick_cnt_q <= tick_cnt_d;
      sat_q      <= sat_d;
    end
  end

  assign minute_o      = minute_q;
  assign open_o        = open_q;
  assign close_o       = close_q;
  assign low_o         = low_q;
  assign high_o        = high_q;
  assign sum_o         = sum_q;
  assign count_o       = count_q;
  assign first_index_o = first_q;
  assign saturated_o   = sat_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ohlc_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle
module ohlc_div #(
  parameter int unsigned DvdW = 45,
  parameter int unsigned DsrW = 17,
  parameter int unsigned QuoW = 28
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire  [DvdW-1:0]  dividend_i,
  input  wire  [DsrW-1:0]  divisor_i,
  output logic             done_o,
  output logic [QuoW-1:0]  quotient_o
);

  localparam int unsigned CntW = $clog2(DvdW + 1);
  localparam logic [CntW-1:0] Steps   = CntW'(DvdW);
  localparam logic [CntW-1:0] LastCnt = CntW'(1);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [DvdW-1:0]   dvd_q;
  logic [DsrW-1:0]   dsr_q;
  logic [DsrW-1:0]   rem_q;
  logic [QuoW-1:0]   quo_q;
  logic [DsrW:0]     rem_sh;
  logic [DsrW:0]     rem_diff;
  logic              fits;

  // remainder stays below the divisor, so the shifted value needs one more bit
  assign rem_sh   = {rem_q, dvd_q[DvdW-1]};
  assign fits     = rem_sh >= {1'b0, dsr_q};
  assign rem_diff = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      dsr_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= Steps;
        dvd_q  <= dividend_i;
        dsr_q  <= divisor_i;
        rem_q  <= '0;
        quo_q  <= '0;
      end else if (busy_q) begin
        dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
        rem_q <= fits ? rem_diff[DsrW-1:0] : rem_sh[DsrW-1:0];
        quo_q <= {quo_q[QuoW-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire
